>>> rtl/assert_macros.svh
// assertion macros for the framed packet receiver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NOW(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_NOW(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/fpr_pkg.sv
// shared types, constants and helpers for the framed packet receiver
package fpr_pkg;

    localparam int PREAMBLE_LENGTH_DEF = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;
    localparam int POS_W = 9;
    localparam int TICK_W = 17;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_FAIL   = 2'd1,
        ST_OK     = 2'd2,
        ST_NONE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_LOCAL_ADDRESS = 2'd0,
        REG_TIMEOUT_TICKS = 2'd1,
        REG_AUTO_RESTART  = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [7:0] source_address;
        logic [7:0] payload_length;
    } res_t;

    typedef struct packed {
        logic [7:0]  local_address;
        logic [15:0] timeout_ticks;
        logic        auto_restart;
    } cfg_t;

    // sync pattern is 1, 2, 3, ... by position
    function automatic logic [7:0] sync_byte(input logic [2:0] idx);
        sync_byte = {5'd0, idx} + 8'd1;
    endfunction

endpackage

>>> rtl/fpr_front.sv
// front end: classifies input words and queues them as commands
module fpr_front
    import fpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;
    cmd_t              cmd_in;

    always_comb
    begin
        cmd_in.data = rx_byte;
        case (kind)
            KIND_BYTE:    cmd_in.op = OP_BYTE;
            KIND_TICK:    cmd_in.op = OP_TICK;
            KIND_RESTART: cmd_in.op = OP_RESTART;
            default:      cmd_in.op = OP_NONE;
        endcase
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/fpr_back.sv
// back end: frame state machine and result queue
module fpr_back
    import fpr_pkg::*;
#(
    parameter int PREAMBLE_LENGTH = PREAMBLE_LENGTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic empty,
    input  logic pop,
    output res_t res
);

    localparam logic [POS_W-1:0] PRE_LEN = POS_W'(PREAMBLE_LENGTH);
    localparam logic [POS_W-1:0] PAY_OFS = POS_W'(PREAMBLE_LENGTH + 2);

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_PREAMBLE = 8'b0000_0010,
        PH_LENGTH   = 8'b0000_0100,
        PH_SOURCE   = 8'b0000_1000,
        PH_DEST     = 8'b0001_0000,
        PH_PAYLOAD  = 8'b0010_0000,
        PH_CHECK    = 8'b0100_0000,
        PH_STOPPED  = 8'b1000_0000
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    phase_t             phase_eff;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [7:0]         xor_reg;
    logic [7:0]         xor_next;
    logic [7:0]         len_reg;
    logic [7:0]         len_next;
    logic [7:0]         src_reg;
    logic [7:0]         src_next;
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_next;
    logic [POS_W-1:0]   pay_index;
    res_t               res_in;
    logic               rearm;

    res_t               res_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               res_full;
    logic               do_pop;

    assign res_full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_pop  = cmd_valid && !res_full;
    assign empty    = (count_reg == '0);
    assign do_pop   = pop && !empty;
    assign res      = res_mem[rd_ptr_reg];

    // payload byte index plus one, relative to first payload byte
    assign pay_index = pos_reg - PAY_OFS;

    always_comb
    begin
        phase_next           = phase_reg;
        phase_eff            = phase_reg;
        pos_next             = pos_reg;
        xor_next             = xor_reg;
        len_next             = len_reg;
        src_next             = src_reg;
        tick_next            = tick_reg;
        rearm                = 1'b0;
        res_in.status        = ST_NONE;
        res_in.payload_byte  = 8'd0;
        res_in.payload_valid = 1'b0;

        case (cmd.op)
            OP_BYTE:
            begin
                res_in.status = ST_ACCEPT;
                phase_eff = (phase_reg == PH_IDLE) ? PH_PREAMBLE : phase_reg;
                phase_next = phase_eff;
                case (phase_eff)
                    PH_PREAMBLE:
                    begin
                        if (pos_reg >= PRE_LEN || cmd.data != sync_byte(pos_reg[2:0]))
                        begin
                            res_in.status = ST_FAIL;
                        end
                        else if (pos_reg + POS_W'(1) >= PRE_LEN)
                        begin
                            phase_next = PH_LENGTH;
                        end
                    end
                    PH_LENGTH:
                    begin
                        len_next   = cmd.data;
                        phase_next = PH_SOURCE;
                    end
                    PH_SOURCE:
                    begin
                        src_next   = cmd.data;
                        phase_next = PH_DEST;
                    end
                    PH_DEST:
                    begin
                        if (cmd.data != cfg.local_address)
                        begin
                            res_in.status = ST_FAIL;
                        end
                        else
                        begin
                            phase_next = (len_reg == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        res_in.payload_byte  = cmd.data;
                        res_in.payload_valid = 1'b1;
                        if (pay_index >= {1'b0, len_reg})
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        res_in.status = (cmd.data == xor_reg) ? ST_OK : ST_FAIL;
                    end
                    default:
                    begin
                        res_in.status = ST_FAIL;
                    end
                endcase
                if (res_in.status == ST_ACCEPT)
                begin
                    xor_next = xor_reg ^ cmd.data;
                    pos_next = pos_reg + 1'b1;
                end
                else if (cfg.auto_restart)
                begin
                    rearm = 1'b1;
                end
                else
                begin
                    phase_next = PH_STOPPED;
                end
            end
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE && phase_reg != PH_STOPPED)
                begin
                    tick_next = tick_reg + 1'b1;
                    if (tick_next > {1'b0, cfg.timeout_ticks})
                    begin
                        phase_next = PH_STOPPED;
                    end
                end
            end
            OP_RESTART:
            begin
                rearm = 1'b1;
            end
            default:
            begin
                rearm = 1'b0;
            end
        endcase

        res_in.source_address = src_next;
        res_in.payload_length = len_next;

        if (rearm)
        begin
            phase_next = PH_IDLE;
            pos_next   = '0;
            xor_next   = '0;
            len_next   = '0;
            src_next   = '0;
            tick_next  = '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd_pop && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_mem[wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            xor_reg    <= '0;
            len_reg    <= '0;
            src_reg    <= '0;
            tick_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd_pop)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                xor_reg    <= xor_next;
                len_reg    <= len_next;
                src_reg    <= src_next;
                tick_reg   <= tick_next;
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/framed_packet_receiver_top.sv
// Throughput: one word per cycle on both sides unless a queue is full or empty; the
// frame state updates once per word in the back end, with four-entry queues between
// input, back end and results.
// Reset (rst_n low, asynchronous): receiver idle, queues empty, local_address 0,
// timeout_ticks 65535, auto_restart 1.
// top level of the framed packet receiver
`include "assert_macros.svh"

module framed_packet_receiver_top
    import fpr_pkg::*;
#(
    parameter int PREAMBLE_LENGTH = PREAMBLE_LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic [7:0]  source_address,
    output logic [7:0]  payload_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_address <= 8'd0;
            cfg_reg.timeout_ticks <= 16'hFFFF;
            cfg_reg.auto_restart  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LOCAL_ADDRESS: cfg_reg.local_address <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                REG_AUTO_RESTART:  cfg_reg.auto_restart  <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    fpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    fpr_back #(
        .PREAMBLE_LENGTH (PREAMBLE_LENGTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign status         = res.status;
    assign payload_byte   = res.payload_byte;
    assign payload_valid  = res.payload_valid;
    assign source_address = res.source_address;
    assign payload_length = res.payload_length;

    `ASSERT_IMPL(a_payload_only_on_accept, clk, rst_n, !empty && payload_valid, status == ST_ACCEPT)
    `ASSERT_NEXT(a_pushed_word_queued, clk, rst_n, push && !full, cmd_valid)
    `ASSERT_IMPL(a_cmd_pop_has_word, clk, rst_n, cmd_pop, cmd_valid)

endmodule

>>> test/testbench.sv
// testbench for framed_packet_receiver_top with a frame-level predictor and random traffic
`timescale 1ns / 100ps

module testbench;
    import fpr_pkg::*;

    localparam int PRE_LEN = PREAMBLE_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREAMBLE,
        PH_LENGTH,
        PH_SOURCE,
        PH_DEST,
        PH_PAYLOAD,
        PH_CHECK,
        PH_STOPPED
    } rx_phase_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_PREAMBLE,
        FLAW_DEST,
        FLAW_CHECKSUM,
        FLAW_TRUNCATE
    } frame_flaw_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
    } link_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  kind = KIND_BYTE;
    logic [7:0]  rx_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [7:0]  source_address;
    logic [7:0]  payload_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_LOCAL_ADDRESS;
    logic [15:0] cfg_data = 16'd0;

    link_word_t  link_words[$];
    res_t        awaited_results[$];
    int          word_total = 0;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 66;

    // predictor copy of the registers and the frame state
    logic [7:0]  cfg_local_address = 8'd0;
    logic [15:0] cfg_timeout = 16'hFFFF;
    logic        cfg_auto_restart = 1'b1;
    rx_phase_t   rx_phase = PH_IDLE;
    logic [8:0]  frame_pos = 9'd0;
    logic [7:0]  frame_xor = 8'd0;
    logic [7:0]  frame_length = 8'd0;
    logic [7:0]  frame_source = 8'd0;
    logic [16:0] frame_ticks = 17'd0;

    framed_packet_receiver_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .payload_byte   (payload_byte),
        .payload_valid  (payload_valid),
        .source_address (source_address),
        .payload_length (payload_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void rearm_receiver();
        rx_phase = PH_IDLE;
        frame_pos = 9'd0;
        frame_xor = 8'd0;
        frame_length = 8'd0;
        frame_source = 8'd0;
        frame_ticks = 17'd0;
    endfunction

    function automatic res_t predict_receiver(input kind_t k, input logic [7:0] b);
        res_t r;
        logic finished;
        r = '0;
        r.status = ST_NONE;
        finished = 1'b0;
        if (k == KIND_BYTE)
        begin
            r.status = ST_ACCEPT;
            if (rx_phase == PH_IDLE)
                rx_phase = PH_PREAMBLE;
            case (rx_phase)
                PH_PREAMBLE:
                    if (int'(frame_pos) >= PRE_LEN || b != 8'(frame_pos[2:0]) + 8'd1)
                        r.status = ST_FAIL;
                    else if (int'(frame_pos) + 1 >= PRE_LEN)
                        rx_phase = PH_LENGTH;
                PH_LENGTH:
                begin
                    frame_length = b;
                    rx_phase = PH_SOURCE;
                end
                PH_SOURCE:
                begin
                    frame_source = b;
                    rx_phase = PH_DEST;
                end
                PH_DEST:
                    if (b != cfg_local_address)
                        r.status = ST_FAIL;
                    else if (frame_length == 8'd0)
                        rx_phase = PH_CHECK;
                    else
                        rx_phase = PH_PAYLOAD;
                PH_PAYLOAD:
                begin
                    r.payload_byte = b;
                    r.payload_valid = 1'b1;
                    if (int'(frame_pos) - (PRE_LEN + 3) + 1 >= int'(frame_length))
                        rx_phase = PH_CHECK;
                end
                PH_CHECK:
                    if (b == frame_xor)
                        r.status = ST_OK;
                    else
                        r.status = ST_FAIL;
                default:
                    r.status = ST_FAIL;
            endcase
            if (r.status == ST_ACCEPT)
            begin
                frame_xor = frame_xor ^ b;
                frame_pos = frame_pos + 9'd1;
            end
            else
            begin
                finished = 1'b1;
            end
        end
        else if (k == KIND_TICK)
        begin
            if (rx_phase != PH_IDLE && rx_phase != PH_STOPPED)
            begin
                frame_ticks = frame_ticks + 17'd1;
                if (frame_ticks > {1'b0, cfg_timeout})
                    rx_phase = PH_STOPPED;
            end
        end
        r.source_address = frame_source;
        r.payload_length = frame_length;
        if (finished)
        begin
            if (cfg_auto_restart)
                rearm_receiver();
            else
                rx_phase = PH_STOPPED;
        end
        else if (k == KIND_RESTART)
        begin
            rearm_receiver();
        end
        return r;
    endfunction

    function automatic void check_field(input string field_name, input int expected,
                                        input int actual);
        if (expected !== actual)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field_name, expected, actual);
            mismatch_count++;
        end
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && link_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push <= 1'b1;
            kind <= link_words[0].kind;
            rx_byte <= link_words[0].data;
        end
        else
        begin
            push <= 1'b0;
        end
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (push && !full)
            begin
                awaited_results.push_back(predict_receiver(kind_t'(kind), rx_byte));
                link_words.delete(0);
            end
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual status %0d",
                             $time, status);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("payload_valid", want.payload_valid, payload_valid);
                    check_field("source_address", want.source_address, source_address);
                    check_field("payload_length", want.payload_length, payload_length);
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic queue_word(input kind_t k, input logic [7:0] b);
        link_word_t w;
        w.kind = k;
        w.data = b;
        link_words.push_back(w);
        if (k != KIND_UNUSED)
            word_total++;
    endtask

    task automatic wait_for_drain();
        while (link_words.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_LOCAL_ADDRESS: cfg_local_address = value[7:0];
            REG_TIMEOUT_TICKS: cfg_timeout = value;
            REG_AUTO_RESTART:  cfg_auto_restart = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] addr, input logic [15:0] limit,
                             input logic arm);
        wait_for_drain();
        write_register(REG_LOCAL_ADDRESS, {8'd0, addr});
        write_register(REG_TIMEOUT_TICKS, limit);
        write_register(REG_AUTO_RESTART, {15'd0, arm});
        @(posedge clk);
    endtask

    task automatic queue_frame(input int unsigned tick_pct);
        frame_flaw_t flaw;
        int          len;
        int          total;
        int          cut;
        int          bad_pos;
        int unsigned pick;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic        flawed;
        if (!cfg_auto_restart && $urandom_range(9) != 0)
            queue_word(KIND_RESTART, 8'($urandom));
        len = ($urandom_range(59) == 0) ? int'($urandom_range(100, 255))
                                        : int'($urandom_range(0, 10));
        total = PRE_LEN + 3 + len + 1;
        cut = $urandom_range(1, total - 1);
        bad_pos = $urandom_range(0, PRE_LEN - 1);
        pick = $urandom_range(99);
        if (pick < 6)
            flaw = FLAW_PREAMBLE;
        else if (pick < 12)
            flaw = FLAW_DEST;
        else if (pick < 20)
            flaw = FLAW_CHECKSUM;
        else if (pick < 26)
            flaw = FLAW_TRUNCATE;
        else
            flaw = FLAW_NONE;
        sum = 8'd0;
        for (int idx = 0; idx < total; idx++)
        begin
            if (flaw == FLAW_TRUNCATE && idx == cut)
                break;
            flawed = 1'b0;
            if (idx < PRE_LEN)
            begin
                b = 8'(idx + 1);
                if (flaw == FLAW_PREAMBLE && idx == bad_pos)
                begin
                    b = b ^ 8'($urandom_range(1, 255));
                    flawed = 1'b1;
                end
            end
            else if (idx == PRE_LEN)
            begin
                b = 8'(len);
            end
            else if (idx == PRE_LEN + 1)
            begin
                b = 8'($urandom);
            end
            else if (idx == PRE_LEN + 2)
            begin
                b = cfg_local_address;
                if (flaw == FLAW_DEST)
                begin
                    b = b ^ 8'($urandom_range(1, 255));
                    flawed = 1'b1;
                end
            end
            else if (idx < total - 1)
            begin
                b = 8'($urandom);
            end
            else
            begin
                b = sum;
                if (flaw == FLAW_CHECKSUM)
                    b = b ^ 8'($urandom_range(1, 255));
            end
            queue_word(KIND_BYTE, b);
            sum = sum ^ b;
            if (flawed)
                break;
            if ($urandom_range(99) < tick_pct)
                queue_word(KIND_TICK, 8'($urandom));
        end
        if (flaw == FLAW_TRUNCATE && $urandom_range(9) < 7)
            queue_word(KIND_RESTART, 8'($urandom));
    endtask

    task automatic random_traffic(input int target, input int unsigned tick_pct);
        int          start;
        int unsigned pick;
        start = word_total;
        while (word_total - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                queue_frame(tick_pct);
            else if (pick < 86)
                queue_word(KIND_BYTE, 8'($urandom));
            else if (pick < 92)
                queue_word(KIND_TICK, 8'($urandom));
            else if (pick < 96)
                queue_word(KIND_RESTART, 8'($urandom));
            else
                queue_word(KIND_UNUSED, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // good frame with no payload
        queue_word(KIND_BYTE, 8'h01);
        queue_word(KIND_BYTE, 8'h02);
        queue_word(KIND_BYTE, 8'h03);
        queue_word(KIND_BYTE, 8'h04);
        queue_word(KIND_BYTE, 8'h00);
        queue_word(KIND_BYTE, 8'hFF);
        queue_word(KIND_BYTE, 8'h00);
        queue_word(KIND_BYTE, 8'hFB);
        // one payload byte, bad checksum
        queue_word(KIND_BYTE, 8'h01);
        queue_word(KIND_BYTE, 8'h02);
        queue_word(KIND_BYTE, 8'h03);
        queue_word(KIND_BYTE, 8'h04);
        queue_word(KIND_BYTE, 8'h01);
        queue_word(KIND_BYTE, 8'h00);
        queue_word(KIND_BYTE, 8'h00);
        queue_word(KIND_BYTE, 8'hFF);
        queue_word(KIND_BYTE, 8'h05);
        // preamble mismatch, idle tick, unused kind, restart mid frame
        queue_word(KIND_BYTE, 8'h00);
        queue_word(KIND_TICK, 8'hFF);
        queue_word(KIND_UNUSED, 8'hAA);
        queue_word(KIND_BYTE, 8'h01);
        queue_word(KIND_RESTART, 8'h55);

        configure(8'hFF, 16'hFFFF, 1'b1);
        write_register(REG_UNUSED, 16'($urandom));
        @(posedge clk);
        random_traffic(300, 10);

        configure(8'($urandom), 16'd0, 1'b1);
        // timeout on the first tick, then a byte while stopped
        queue_word(KIND_BYTE, 8'h01);
        queue_word(KIND_TICK, 8'h00);
        queue_word(KIND_BYTE, 8'h02);
        random_traffic(220, 3);

        wait_for_drain();
        send_idle_pct = 66;
        recv_idle_pct = 17;
        configure(8'($urandom), 16'($urandom_range(2, 12)), 1'b0);
        random_traffic(330, 10);

        configure(8'h00, 16'hFFFF, 1'b0);
        random_traffic(300, 8);

        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(8'($urandom), 16'($urandom_range(0, 40)), 1'b1);
        random_traffic(400, 12);

        configure(8'($urandom), 16'($urandom), 1'($urandom));
        random_traffic(400, 8);

        wait_for_drain();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
